>>> hw/rtl/tone_melody_sequencer_core_defines.svh
// assertion macros for the tone melody sequencer core
// used by the top level only; assumes signals named clock and reset in scope
`ifndef TONE_MELODY_SEQUENCER_CORE_DEFINES_SVH
`define TONE_MELODY_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define TMS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tms same-cycle check failed");

// next-cycle implication
`define TMS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tms next-cycle check failed");

`endif

>>> hw/rtl/tms_pkg.sv
// shared types and constants for the tone melody sequencer
// no dependencies
`timescale 1ns / 1ps

package tms_pkg;

   localparam int MAX_NOTES   = 256;
   localparam int IDX_W       = $clog2(MAX_NOTES);
   localparam int SONG_LEN_W  = 9;
   localparam int CNT_W       = ($clog2(MAX_NOTES + 1) > SONG_LEN_W) ?
                                $clog2(MAX_NOTES + 1) : SONG_LEN_W;
   localparam int TIME_W      = 32;
   localparam int DUR_W       = 16;
   localparam int HP_W        = 16;
   localparam int SDUR_W      = 17;
   localparam int SPD_W       = 8;
   localparam int ENTRY_W     = DUR_W + HP_W;
   localparam int EIDX_W      = 8;
   localparam int NOTE_POS_W  = 8;

   localparam logic [SPD_W-1:0] SPEED_UNITY = 8'h80;
   localparam int SLOW_SHIFT  = 7;      // divide by 0x80
   localparam int FastDiv     = 255;    // 0xff
   localparam int RECIP_SHIFT = 31;
   localparam int RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] FAST_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / FastDiv);

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_PLAY  = 2'd1,
      OP_STOP  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_LOOP    = 2'd0,
      CSR_REVERSE = 2'd1,
      CSR_SPEED   = 2'd2,
      CSR_SONGLEN = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             start;
      logic [DUR_W-1:0] duration;
      logic [SPD_W-1:0] speed;
   } scale_req_type;

   typedef struct packed {
      logic              done;
      logic [SDUR_W-1:0] duration;
   } scale_rsp_type;

endpackage

>>> hw/rtl/tms_note_mem.sv
// note table: one write port, one registered read port
// depends on tms_pkg
`timescale 1ns / 1ps

module tms_note_mem (
   input  logic                        clock,
   input  tms_pkg::mem_req_type        mem_req,
   output logic [tms_pkg::ENTRY_W-1:0] rd_data
);
   import tms_pkg::*;

   logic [ENTRY_W-1:0] note_mem [MAX_NOTES];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         note_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= note_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tms_dur_scale.sv
// three-stage duration scaler: d + d*(s-128)/128 or d - d*(128-s)/255
// depends on tms_pkg
`timescale 1ns / 1ps

module tms_dur_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  tms_pkg::scale_req_type scl_req,
   output tms_pkg::scale_rsp_type scl_rsp
);
   import tms_pkg::*;

   localparam int PROD_W = DUR_W + SPD_W;
   localparam int X_W    = DUR_W + SLOW_SHIFT;
   localparam int Y_W    = X_W + RECIP_W;

   // stage 1: magnitude product
   logic              v1_ff, v1_in;
   logic              slow1_ff, fast1_ff;
   logic [DUR_W-1:0]  d1_ff;
   logic [PROD_W-1:0] p1_ff;
   logic [SPD_W-1:0]  mag;

   // stage 2: reciprocal product for the shortening case
   logic              v2_ff, v2_in;
   logic              fast2_ff;
   logic [DUR_W-1:0]  d2_ff;
   logic [X_W-1:0]    x2_ff;
   logic [Y_W-1:0]    y2_ff;
   logic [SDUR_W-1:0] alt2_ff, alt2;

   // stage 3: correction and subtract
   logic              v3_ff, v3_in;
   logic [SDUR_W-1:0] res3_ff, res3;
   logic [DUR_W-1:0]  q_est, q_fix;
   logic [X_W:0]      q_mul, rem;

   assign mag = (scl_req.speed > SPEED_UNITY) ? (scl_req.speed - SPEED_UNITY)
                                              : (SPEED_UNITY - scl_req.speed);
   assign v1_in = scl_req.start;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;

   always_comb begin
      if (slow1_ff) begin
         alt2 = SDUR_W'(d1_ff) + SDUR_W'(p1_ff >> SLOW_SHIFT);
      end else begin
         alt2 = SDUR_W'(d1_ff);
      end
   end

   // estimate is exact or one low, a single compare fixes it
   assign q_est = y2_ff[RECIP_SHIFT +: DUR_W];
   assign q_mul = ((X_W+1)'(q_est) << 8) - (X_W+1)'(q_est);
   assign rem   = (X_W+1)'(x2_ff) - q_mul;
   assign q_fix = q_est + DUR_W'(rem >= (X_W+1)'(FastDiv));

   always_comb begin
      if (fast2_ff) begin
         res3 = SDUR_W'(d2_ff) - SDUR_W'(q_fix);
      end else begin
         res3 = alt2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      slow1_ff <= scl_req.speed > SPEED_UNITY;
      fast1_ff <= scl_req.speed < SPEED_UNITY;
      d1_ff    <= scl_req.duration;
      p1_ff    <= scl_req.duration * mag;
      fast2_ff <= fast1_ff;
      d2_ff    <= d1_ff;
      x2_ff    <= X_W'(p1_ff);
      y2_ff    <= X_W'(p1_ff) * FAST_RECIP;
      alt2_ff  <= alt2;
      res3_ff  <= res3;
   end

   assign scl_rsp.done     = v3_ff;
   assign scl_rsp.duration = res3_ff;

endmodule

>>> hw/rtl/tone_melody_sequencer_core.sv
// top level of the tone melody sequencer: control, registers and handshakes
// depends on tms_pkg, tms_note_mem, tms_dur_scale and the assertion header
//
// channel  dir  handshake              content
// req      in   req_tvalid/req_tready  operation in tuser, time and table entry in tdata
// rsp      out  rsp_tvalid/rsp_tready  speaker, playing, note position in tdata
// csr      in   csr_valid/csr_ready    register index and write data, always ready
//
// play, stop, write and a tick without a note change are handled when accepted; the
// result is registered and shown the next cycle. a tick that starts a note goes
// through the accepting cycle, the table read and three scaler stages. synchronous
// reset clears all control state; the table is undefined until written. a new beat is
// taken only when the result register is empty or being drained in the same cycle.
`timescale 1ns / 1ps

module tone_melody_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // now[31:0], entry_index[39:32],
                                   // entry_duration[55:40], entry_half_period[71:56]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // speaker[0], playing[1], note_position[9:2], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [tms_pkg::SONG_LEN_W-1:0] csr_data
);
   import tms_pkg::*;

`include "tone_melody_sequencer_core_defines.svh"

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_READ  = 3'b010,
      S_SCALE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic                   playing_ff, playing_in;
   logic                   started_ff, started_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [TIME_W-1:0]      note_start_ff, note_start_in;
   logic [TIME_W-1:0]      last_toggle_ff, last_toggle_in;
   logic [SDUR_W-1:0]      cur_dur_ff, cur_dur_in;
   logic [HP_W-1:0]        cur_hp_ff, cur_hp_in;
   logic                   spk_ff, spk_in;
   logic                   loop_ff, loop_in;
   logic                   rev_ff, rev_in;
   logic [SPD_W-1:0]       speed_ff, speed_in;
   logic [SONG_LEN_W-1:0]  song_len_ff, song_len_in;
   logic [TIME_W-1:0]      pend_now_ff, pend_now_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   op_type                 req_op;
   logic [TIME_W-1:0]      req_now;
   logic [EIDX_W-1:0]      req_eidx;
   logic [DUR_W-1:0]       req_edur;
   logic [HP_W-1:0]        req_ehp;
   logic                   req_fire, csr_fire;

   logic [TIME_W-1:0]      elapsed, since_toggle;
   logic [SDUR_W-1:0]      need_dur;
   logic                   need_note, at_end, stop_now;
   logic [CNT_W-1:0]       song_len_x, play_len, idx_raw, idx_sel, slot;

   mem_req_type            mem_req;
   logic [ENTRY_W-1:0]     rd_data;
   scale_req_type          scl_req;
   scale_rsp_type          scl_rsp;

   assign req_op   = op_type'(req_tuser);
   assign req_now  = req_tdata[31:0];
   assign req_eidx = req_tdata[39:32];
   assign req_edur = req_tdata[55:40];
   assign req_ehp  = req_tdata[71:56];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;

   // note-change decision from the current state and the beat's time
   assign elapsed      = started_ff ? (req_now - note_start_ff) : '0;
   assign need_dur     = started_ff ? cur_dur_ff : '0;
   assign need_note    = elapsed >= TIME_W'(need_dur);
   assign since_toggle = req_now - last_toggle_ff;

   assign song_len_x = CNT_W'(song_len_ff);
   assign play_len   = (song_len_x > CNT_W'(MAX_NOTES)) ? CNT_W'(MAX_NOTES) : song_len_x;
   assign idx_raw    = started_ff ? (CNT_W'(pos_ff) + 1'b1) : '0;
   assign at_end     = idx_raw >= play_len;
   assign stop_now   = at_end && !(loop_ff && (play_len != '0));
   assign idx_sel    = at_end ? '0 : idx_raw;
   assign slot       = rev_ff ? (play_len - idx_sel - 1'b1) : idx_sel;

   always_comb begin
      state_in       = state_ff;
      playing_in     = playing_ff;
      started_in     = started_ff;
      pos_in         = pos_ff;
      note_start_in  = note_start_ff;
      last_toggle_in = last_toggle_ff;
      cur_dur_in     = cur_dur_ff;
      cur_hp_in      = cur_hp_ff;
      spk_in         = spk_ff;
      loop_in        = loop_ff;
      rev_in         = rev_ff;
      speed_in       = speed_ff;
      song_len_in    = song_len_ff;
      pend_now_in    = pend_now_ff;
      pend_idx_in    = pend_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = IDX_W'(req_eidx);
      mem_req.wr_data = {req_edur, req_ehp};
      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = IDX_W'(slot);

      scl_req.start    = 1'b0;
      scl_req.duration = rd_data[ENTRY_W-1:HP_W];
      scl_req.speed    = speed_ff;

      if (csr_fire) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LOOP:    loop_in     = csr_data[0];
            CSR_REVERSE: rev_in      = csr_data[0];
            CSR_SPEED:   speed_in    = csr_data[SPD_W-1:0];
            CSR_SONGLEN: song_len_in = csr_data;
            default:     ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               unique case (req_op)
                  OP_TICK: begin
                     if (playing_ff) begin
                        if (need_note) begin
                           if (stop_now) begin
                              playing_in = 1'b0;
                              started_in = 1'b0;
                              pos_in     = '0;
                              spk_in     = 1'b0;
                           end else begin
                              mem_req.rd_en = 1'b1;
                              pend_now_in   = req_now;
                              pend_idx_in   = IDX_W'(idx_sel);
                              rsp_valid_in  = 1'b0;
                              state_in      = S_READ;
                           end
                        end else if (cur_hp_ff == '0) begin
                           spk_in = 1'b0;
                        end else if (since_toggle >= TIME_W'(cur_hp_ff)) begin
                           spk_in         = !spk_ff;
                           last_toggle_in = req_now;
                        end
                     end
                  end
                  OP_PLAY: begin
                     playing_in = 1'b1;
                     started_in = 1'b0;
                     pos_in     = '0;
                     spk_in     = 1'b0;
                  end
                  OP_STOP: begin
                     playing_in = 1'b0;
                     started_in = 1'b0;
                     pos_in     = '0;
                     spk_in     = 1'b0;
                  end
                  OP_WRITE: begin
                     mem_req.wr_en = 32'(req_eidx) < MAX_NOTES;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            // fresh note: toggle timer restarts, so only a rest changes the pin
            cur_hp_in      = rd_data[HP_W-1:0];
            if (rd_data[HP_W-1:0] == '0) begin
               spk_in = 1'b0;
            end
            pos_in         = pend_idx_ff;
            started_in     = 1'b1;
            note_start_in  = pend_now_ff;
            last_toggle_in = pend_now_ff;
            scl_req.start  = 1'b1;
            state_in       = S_SCALE;
         end
         S_SCALE: begin
            if (scl_rsp.done) begin
               cur_dur_in   = scl_rsp.duration;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         playing_ff     <= 1'b0;
         started_ff     <= 1'b0;
         pos_ff         <= '0;
         note_start_ff  <= '0;
         last_toggle_ff <= '0;
         cur_dur_ff     <= '0;
         cur_hp_ff      <= '0;
         spk_ff         <= 1'b0;
         loop_ff        <= 1'b0;
         rev_ff         <= 1'b0;
         speed_ff       <= SPEED_UNITY;
         song_len_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         playing_ff     <= playing_in;
         started_ff     <= started_in;
         pos_ff         <= pos_in;
         note_start_ff  <= note_start_in;
         last_toggle_ff <= last_toggle_in;
         cur_dur_ff     <= cur_dur_in;
         cur_hp_ff      <= cur_hp_in;
         spk_ff         <= spk_in;
         loop_ff        <= loop_in;
         rev_ff         <= rev_in;
         speed_ff       <= speed_in;
         song_len_ff    <= song_len_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pend_now_ff <= pend_now_in;
      pend_idx_ff <= pend_idx_in;
   end

   tms_note_mem u_note_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   tms_dur_scale u_dur_scale (
      .clock   (clock),
      .reset   (reset),
      .scl_req (scl_req),
      .scl_rsp (scl_rsp)
   );

   // state holds while a result waits, so the beat is taken straight from it
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        (started_ff ? NOTE_POS_W'(pos_ff) : NOTE_POS_W'(0)),
                        playing_ff, spk_ff};

   `TMS_ASSERT_SAME(a_done_in_scale, scl_rsp.done, state_ff == S_SCALE)
   `TMS_ASSERT_NEXT(a_fetch_goes_read, mem_req.rd_en, state_ff == S_READ)
   `TMS_ASSERT_NEXT(a_read_then_scale, state_ff == S_READ, state_ff == S_SCALE)
   `TMS_ASSERT_SAME(a_stopped_no_pos, rsp_tvalid && !rsp_tdata[1], rsp_tdata[9:2] == 8'd0)

endmodule

>>> bench/tone_melody_sequencer_core_checker.sv
// result checker for the tone melody sequencer core: watches the request, result and
// register channels, predicts every result beat and compares it field by field
// depends on tms_pkg
`timescale 1ns / 1ps

module tone_melody_sequencer_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,  // now[31:0], entry_index[39:32],
                                   // entry_duration[55:40], entry_half_period[71:56]
   input  logic [1:0]  req_tuser,  // operation[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,  // speaker[0], playing[1], note_position[9:2]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [tms_pkg::SONG_LEN_W-1:0] csr_data,
   output int          error_count,
   output int          pending_count,
   output int          checked_count,
   output int          note_change_count
);
   import tms_pkg::*;

   localparam int unsigned SLOW_DIVISOR = 'h80;
   localparam int unsigned FAST_DIVISOR = 'hFF;

   // laid out like rsp_tdata[9:0]
   typedef struct packed {
      logic [7:0] position;
      logic       playing;
      logic       speaker;
   } tone_result_type;

   tone_result_type expected_tones[$];

   logic [31:0] note_mem [0:MAX_NOTES-1];
   logic        is_playing;
   logic        has_note;
   logic        spk_level;
   logic [7:0]  note_pos;
   logic [31:0] note_t0;
   logic [31:0] toggle_t0;
   logic [16:0] note_len;
   logic [15:0] note_hp;

   logic        loop_on;
   logic        reverse_on;
   logic [7:0]  speed_reg;
   logic [8:0]  song_len_reg;

   function automatic logic [16:0] scale_duration(input logic [15:0] d, input logic [7:0] s);
      int unsigned dd;
      int unsigned ss;
      int unsigned r;
      dd = d;
      ss = s;
      if (ss > SPEED_UNITY) r = dd + (dd * (ss - SPEED_UNITY)) / SLOW_DIVISOR;
      else if (ss < SPEED_UNITY) r = dd - (dd * (SPEED_UNITY - ss)) / FAST_DIVISOR;
      else r = dd;
      return r[16:0];
   endfunction

   task automatic stop_playback;
      is_playing = 1'b0;
      has_note   = 1'b0;
      note_pos   = 8'd0;
      spk_level  = 1'b0;
   endtask

   task automatic play_tick(input logic [31:0] now);
      int unsigned len;
      int unsigned idx;
      int unsigned slot;
      logic [31:0] entry;
      logic [31:0] elapsed;
      if (!is_playing) return;
      if (!has_note) begin
         note_t0  = now;
         note_len = 17'd0;
      end
      elapsed = now - note_t0;
      if (elapsed >= note_len) begin
         len = (song_len_reg > MAX_NOTES) ? MAX_NOTES : song_len_reg;
         idx = has_note ? int'(note_pos) + 1 : 0;
         if (idx >= len) begin
            // an empty song stops even with looping on
            if (loop_on && len > 0) begin
               idx = 0;
            end else begin
               stop_playback();
               return;
            end
         end
         slot = reverse_on ? len - idx - 1 : idx;
         entry = note_mem[slot % MAX_NOTES];
         note_pos  = idx[7:0];
         has_note  = 1'b1;
         note_t0   = now;
         toggle_t0 = now;
         note_len  = scale_duration(entry[31:16], speed_reg);
         note_hp   = entry[15:0];
         note_change_count++;
      end
      elapsed = now - toggle_t0;
      if (note_hp == 16'd0) begin
         spk_level = 1'b0;
      end else if (elapsed >= note_hp) begin
         spk_level = ~spk_level;
         toggle_t0 = now;
      end
   endtask

   always @(posedge clock) begin : monitor
      tone_result_type got;
      tone_result_type want;
      if (reset) begin
         is_playing   = 1'b0;
         has_note     = 1'b0;
         spk_level    = 1'b0;
         note_pos     = 8'd0;
         note_t0      = 32'd0;
         toggle_t0    = 32'd0;
         note_len     = 17'd0;
         note_hp      = 16'd0;
         loop_on      = 1'b0;
         reverse_on   = 1'b0;
         speed_reg    = SPEED_UNITY;
         song_len_reg = 9'd0;
         expected_tones.delete();
         error_count       = 0;
         pending_count     = 0;
         checked_count     = 0;
         note_change_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_idx_type'(csr_index))
               CSR_LOOP:    loop_on      = csr_data[0];
               CSR_REVERSE: reverse_on   = csr_data[0];
               CSR_SPEED:   speed_reg    = csr_data[7:0];
               CSR_SONGLEN: song_len_reg = csr_data[8:0];
            endcase
         end

         // the result of a beat accepted at this edge can only show later
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[9:0];
            if (expected_tones.size() == 0) begin
               $error("result beat 0x%h with no request waiting", rsp_tdata);
               error_count++;
            end else begin
               want = expected_tones.pop_front();
               checked_count++;
               if (got.speaker !== want.speaker) begin
                  $error("speaker mismatch: expected %0d, actual %0d",
                         want.speaker, got.speaker);
                  error_count++;
               end
               if (got.playing !== want.playing) begin
                  $error("playing mismatch: expected %0d, actual %0d",
                         want.playing, got.playing);
                  error_count++;
               end
               if (got.position !== want.position) begin
                  $error("note_position mismatch: expected %0d, actual %0d",
                         want.position, got.position);
                  error_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            unique case (op_type'(req_tuser))
               OP_TICK: play_tick(req_tdata[31:0]);
               OP_PLAY: begin
                  stop_playback();
                  is_playing = 1'b1;
               end
               OP_STOP: stop_playback();
               OP_WRITE: note_mem[req_tdata[39:32]] = {req_tdata[55:40], req_tdata[71:56]};
            endcase
            want.speaker  = spk_level;
            want.playing  = is_playing;
            want.position = has_note ? note_pos : 8'd0;
            expected_tones.push_back(want);
         end
         pending_count = expected_tones.size();
      end
   end

endmodule

>>> bench/tone_melody_sequencer_core_tb.sv
// testbench top for the tone melody sequencer core: clock, reset, stimulus and verdict
// depends on tms_pkg, tone_melody_sequencer_core and tone_melody_sequencer_core_checker
`timescale 1ns / 1ps

module tone_melody_sequencer_core_tb;
   import tms_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 12;
   localparam int SEGMENTS     = 5;
   localparam int SEG_BEATS    = 50;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [SONG_LEN_W-1:0] csr_data;

   int errors;
   int pending;
   int checked;
   int note_changes;
   int beats_sent;
   int reg_writes;
   int quiet_cycles;
   int sender_idle_pct;
   int receiver_stall_pct;
   logic [31:0] song_time;

   tone_melody_sequencer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tone_melody_sequencer_core_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .error_count       (errors),
      .pending_count     (pending),
      .checked_count     (checked),
      .note_change_count (note_changes)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // valid stays high from one beat to the next unless an idle gap is drawn
   task automatic send_beat(input op_type op, input logic [31:0] now, input logic [7:0] idx,
                            input logic [15:0] dur, input logic [15:0] hp);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {hp, dur, idx, now};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_tick(input logic [31:0] now);
      send_beat(OP_TICK, now, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic send_op(input op_type op);
      send_beat(op, $urandom, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic send_write(input logic [7:0] idx, input logic [15:0] dur,
                             input logic [15:0] hp);
      send_beat(OP_WRITE, $urandom, idx, dur, hp);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [8:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
   endtask

   task automatic wait_drained;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(input logic lp, input logic rv, input logic [7:0] spd,
                             input logic [8:0] len);
      wait_drained();
      write_reg(CSR_LOOP, {8'd0, lp});
      write_reg(CSR_REVERSE, {8'd0, rv});
      write_reg(CSR_SPEED, {1'b0, spd});
      write_reg(CSR_SONGLEN, len);
   endtask

   // mostly short notes so that playback moves through the song
   function automatic logic [15:0] pick_duration;
      if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
      return 16'($urandom_range(40));
   endfunction

   function automatic logic [15:0] pick_half_period;
      if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
      if ($urandom_range(4) == 0) return 16'd0;
      return 16'($urandom_range(15));
   endfunction

   function automatic logic [7:0] pick_speed;
      case ($urandom_range(6))
         0: return 8'd0;
         1: return 8'd255;
         2: return SPEED_UNITY;
         3: return SPEED_UNITY - 8'd1;
         4: return SPEED_UNITY + 8'd1;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [8:0] pick_song_length;
      case ($urandom_range(9))
         0: return 9'd0;
         1: return 9'd256;
         2: return 9'd511;
         3: return 9'($urandom_range(511));
         4: return 9'd255;
         default: return 9'($urandom_range(8, 1));
      endcase
   endfunction

   function automatic logic [31:0] time_step;
      case ($urandom_range(19))
         0: return $urandom;
         1, 2: return 32'd0;
         3, 4: return $urandom_range(400);
         default: return $urandom_range(24);
      endcase
   endfunction

   initial begin : stimulus
      int sender_pcts [4];
      int receiver_pcts [4];
      int r;
      sender_pcts   = '{0, 51, 0, 18};
      receiver_pcts = '{0, 0, 51, 18};
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_TICK;
      rsp_tready = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = CSR_LOOP;
      csr_data   = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      beats_sent = 0;
      reg_writes = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tick while stopped, then a four-note song with a rest, a toggle and a longest note
      send_tick(32'hFFFF_FFFF);
      send_write(8'd0, 16'd0, 16'd0);
      send_write(8'd1, 16'd10, 16'd3);
      send_write(8'd2, 16'hFFFF, 16'hFFFF);
      send_write(8'd3, 16'd5, 16'd0);
      set_config(1'b0, 1'b0, SPEED_UNITY, 9'd4);
      send_op(OP_PLAY);
      send_tick(32'd100);
      send_tick(32'd100);
      send_tick(32'd103);
      send_tick(32'd110);
      send_tick(32'd110 + 32'd65535);
      send_tick(32'd110 + 32'd65540);
      // play while playing, and time running across the 32-bit wrap
      send_op(OP_PLAY);
      send_tick(32'hFFFF_FFFA);
      send_op(OP_PLAY);
      send_tick(32'hFFFF_FFFE);
      send_tick(32'h0000_0003);
      send_op(OP_STOP);
      send_tick(32'h0000_0008);

      // fill the whole table so that every later read hits a written entry
      for (int i = 0; i < MAX_NOTES; i++) send_write(i[7:0], pick_duration(), pick_half_period());

      // an empty song stops even with looping on
      set_config(1'b1, 1'b0, SPEED_UNITY, 9'd0);
      send_op(OP_PLAY);
      send_tick(32'd1000);
      // oversized song length, reversed, slowest speed
      set_config(1'b1, 1'b1, 8'd255, 9'd511);
      send_op(OP_PLAY);
      send_tick(32'd2000);
      send_tick(32'd2000);

      song_time = $urandom;
      for (int phase = 0; phase < 4; phase++) begin
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            set_config(1'($urandom_range(1)), 1'($urandom_range(1)), pick_speed(),
                       pick_song_length());
            sender_idle_pct    = sender_pcts[phase];
            receiver_stall_pct = receiver_pcts[phase];
            send_op(OP_PLAY);
            repeat (SEG_BEATS) begin
               r = $urandom_range(99);
               if (r < 78) begin
                  song_time = song_time + time_step();
                  send_tick(song_time);
               end else if (r < 84) begin
                  send_op(OP_PLAY);
               end else if (r < 88) begin
                  send_op(OP_STOP);
               end else begin
                  send_write(8'($urandom_range(255)), pick_duration(), pick_half_period());
               end
            end
         end
      end

      wait_drained();
      $display("checked %0d results from %0d request beats: %0d note changes, %0d register writes",
               checked, beats_sent, note_changes, reg_writes);
      $display("pressure profiles: none, sender idle, receiver stall, both");
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
